/* hw/rtl/vgcd_pkg.sv */
// ============================================================================
// vgcd_pkg
// Shared types, constants and helpers of the volume gradient unit.
// ============================================================================
package vgcd_pkg;

    // Default size limits of the volume
    localparam int VGCD_MAX_X = 256;
    localparam int VGCD_MAX_Y = 256;
    localparam int VGCD_MAX_Z = 4096;

    // Configuration register indexes
    localparam logic [1:0] CFG_DIM_X = 2'd0;
    localparam logic [1:0] CFG_DIM_Y = 2'd1;
    localparam logic [1:0] CFG_DIM_Z = 2'd2;

    // Cycles the derived geometry needs after reset or a register write
    localparam logic [2:0] SETTLE_CYC = 3'd5;

    // Depth of the queue between front and back
    localparam int Q_DEPTH = 4;

    // Gradient word constants
    localparam logic [15:0] ZERO_LEVEL = 16'd16384;
    localparam logic [15:0] SCALE_MARK = 16'd32767;

    // One classified item on its way to the back part
    typedef struct packed {
        logic [7:0] voxel;  // value pushed into the window (zero on drain)
        logic       emit;   // a result leaves with this push
        logic       first;  // first result of the volume
        logic       last;   // final result of the volume
        logic       face_x;
        logic       face_y;
        logic       face_z;
    } t_op;

    // low 16 bits of 16384 + 128*(hi - lo)
    function automatic logic [15:0] grad_word(logic [7:0] hi, logic [7:0] lo);
        logic [15:0] a;
        logic [15:0] b;
        a = {1'b0, hi, 7'b0};
        b = {1'b0, lo, 7'b0};
        return ZERO_LEVEL + a - b;
    endfunction

endpackage

/* hw/rtl/vgcd_delay.sv */
// ============================================================================
// vgcd_delay
// Circular voxel delay line, run-time length; one push per cycle while i_en.
// ============================================================================
module vgcd_delay import vgcd_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [$clog2(DEPTH+1)-1:0] i_len,
    input  logic [7:0]                 i_din,
    output logic [7:0]                 o_dout
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    logic [7:0]    r_mem [DEPTH];
    logic [PW-1:0] r_ptr;
    logic [PW-1:0] n_ptr;
    logic [7:0]    r_dout;

    // wrap at the programmed length
    always_comb begin
        if (LW'(r_ptr) + LW'(1) >= i_len) begin
            n_ptr = '0;
        end else begin
            n_ptr = r_ptr + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_en) begin
            r_ptr <= n_ptr;
        end
    end

    // read old entry, then overwrite with the new voxel
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dout       <= r_mem[r_ptr];
            r_mem[r_ptr] <= i_din;
        end
    end

    assign o_dout = r_dout;

endmodule

/* hw/rtl/vgcd_queue.sv */
// ============================================================================
// vgcd_queue
// Small FIFO of classified items between front and back.
// ============================================================================
module vgcd_queue import vgcd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_op  o_op
);

    localparam int AW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_op           r_mem [Q_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] p);
        if (32'(p) == Q_DEPTH - 1) begin
            return '0;
        end
        return p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= wrap_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= wrap_inc(r_rd);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    assign o_full  = (r_cnt == CW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rd];

endmodule

/* hw/rtl/vgcd_front.sv */
// ============================================================================
// vgcd_front
// Accepts voxels and drains, counts the volume and decides which item
// releases a result and where that result lies.
// ============================================================================
module vgcd_front import vgcd_pkg::*; #(
    parameter int MAX_DIM_X = VGCD_MAX_X,
    parameter int MAX_DIM_Y = VGCD_MAX_Y,
    parameter int MAX_DIM_Z = VGCD_MAX_Z
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_restart,
    input  logic                       i_hold,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_voxel,
    input  logic                       i_drain,
    input  logic [$clog2(MAX_DIM_X)-1:0] i_dx_m1,
    input  logic [$clog2(MAX_DIM_Y)-1:0] i_dy_m1,
    input  logic [$clog2(MAX_DIM_Z)-1:0] i_dz_m1,
    input  logic [$clog2(MAX_DIM_X*MAX_DIM_Y+1)-1:0] i_plane,
    input  logic [$clog2(longint'(MAX_DIM_X)*longint'(MAX_DIM_Y)*longint'(MAX_DIM_Z)+1)-1:0]
                                       i_total,
    input  logic [$clog2(longint'(MAX_DIM_X)*longint'(MAX_DIM_Y)*longint'(MAX_DIM_Z)+1)-1:0]
                                       i_total_m1,
    input  logic                       i_q_full,
    output logic                       o_push,
    output t_op                        o_op
);

    localparam int XPW = $clog2(MAX_DIM_X);
    localparam int YPW = $clog2(MAX_DIM_Y);
    localparam int ZPW = $clog2(MAX_DIM_Z);
    localparam int CW  =
        $clog2(longint'(MAX_DIM_X) * longint'(MAX_DIM_Y) * longint'(MAX_DIM_Z) + 1);

    logic [CW-1:0]  r_cnt, n_cnt;
    logic [CW-1:0]  r_lead, n_lead;
    logic [XPW-1:0] r_x, n_x;
    logic [YPW-1:0] r_y, n_y;
    logic [ZPW-1:0] r_z, n_z;

    logic          accept;
    logic          wr;
    logic          full_n;
    logic [CW-1:0] lead_n;
    logic          emit;
    logic          first;
    logic          last;

    assign o_ready = !i_hold && !i_q_full;
    assign accept  = i_valid && o_ready;

    // classify the item
    always_comb begin
        wr     = !i_drain && (r_cnt < i_total);
        full_n = (r_cnt == i_total) || (wr && (r_cnt == i_total_m1));
        lead_n = r_lead + CW'(wr);
        emit   = full_n || (lead_n > CW'(i_plane));
        first  = (r_x == '0) && (r_y == '0) && (r_z == '0);
        last   = (r_x == i_dx_m1) && (r_y == i_dy_m1) && (r_z == i_dz_m1);

        o_op.voxel  = wr ? i_voxel : 8'd0;
        o_op.emit   = emit;
        o_op.first  = first;
        o_op.last   = last;
        o_op.face_x = (r_x == '0) || (r_x == i_dx_m1);
        o_op.face_y = (r_y == '0) || (r_y == i_dy_m1);
        o_op.face_z = (r_z == '0) || (r_z == i_dz_m1);
        o_push      = accept && (wr || emit);
    end

    // counters and output position
    always_comb begin
        n_cnt  = r_cnt;
        n_lead = r_lead;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        if (accept) begin
            if (emit && last) begin
                n_cnt  = '0;
                n_lead = '0;
                n_x    = '0;
                n_y    = '0;
                n_z    = '0;
            end else begin
                n_cnt  = r_cnt + CW'(wr);
                n_lead = lead_n - CW'(emit);
                if (emit) begin
                    if (r_x == i_dx_m1) begin
                        n_x = '0;
                        if (r_y == i_dy_m1) begin
                            n_y = '0;
                            n_z = r_z + ZPW'(1);
                        end else begin
                            n_y = r_y + YPW'(1);
                        end
                    end else begin
                        n_x = r_x + XPW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_cnt  <= '0;
            r_lead <= '0;
            r_x    <= '0;
            r_y    <= '0;
            r_z    <= '0;
        end else begin
            r_cnt  <= n_cnt;
            r_lead <= n_lead;
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
        end
    end

endmodule

/* hw/rtl/vgcd_back.sv */
// ============================================================================
// vgcd_back
// Window of two planes as a chain of delay memories; forms the three
// central differences and holds the result for the output side.
// ============================================================================
module vgcd_back import vgcd_pkg::*; #(
    parameter int MAX_DIM_X = VGCD_MAX_X,
    parameter int MAX_DIM_Y = VGCD_MAX_Y
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_q_valid,
    input  t_op                                    i_q_op,
    output logic                                   o_q_pop,
    input  logic [$clog2(MAX_DIM_X+1)-1:0]         i_line_len,
    input  logic [$clog2(MAX_DIM_X*MAX_DIM_Y+1)-1:0] i_plane_len,
    output logic                                   o_tvalid,
    input  logic                                   i_tready,
    output logic [47:0]                            o_tdata,
    output logic                                   o_tlast
);

    localparam int PLANE_DEPTH = MAX_DIM_X * MAX_DIM_Y;

    logic       adv;
    logic       s2_move;
    logic       r_s2_valid;
    t_op        r_s2_op;

    // window taps, named by offset from the result voxel
    logic [7:0] r_t_pp;   // +plane (newest)
    logic [7:0] t_px;     // +dx
    logic [7:0] t_p1;     // +1
    logic [7:0] r_t_0;    // center
    logic [7:0] r_t_m1;   // -1
    logic [7:0] t_mx;     // -dx
    logic [7:0] t_mp;     // -plane

    logic [15:0] gx, gy, gz;

    logic        r_o_valid;
    logic [47:0] r_o_data;
    logic        r_o_last;

    assign s2_move = r_s2_valid && (!r_o_valid || i_tready);
    assign adv     = i_q_valid && (!r_s2_valid || s2_move);
    assign o_q_pop = adv;

    // delay chain
    vgcd_delay #(.DEPTH(PLANE_DEPTH)) u_plane_hi (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv),
        .i_len(i_plane_len), .i_din(r_t_pp), .o_dout(t_px)
    );

    vgcd_delay #(.DEPTH(MAX_DIM_X)) u_line_hi (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv),
        .i_len(i_line_len), .i_din(t_px), .o_dout(t_p1)
    );

    vgcd_delay #(.DEPTH(MAX_DIM_X)) u_line_lo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv),
        .i_len(i_line_len), .i_din(r_t_m1), .o_dout(t_mx)
    );

    vgcd_delay #(.DEPTH(PLANE_DEPTH)) u_plane_lo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv),
        .i_len(i_plane_len), .i_din(t_mx), .o_dout(t_mp)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_t_pp  <= i_q_op.voxel;
            r_t_0   <= t_p1;
            r_t_m1  <= r_t_0;
            r_s2_op <= i_q_op;
        end
    end

    // result pending behind the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= i_q_op.emit;
        end else if (s2_move) begin
            r_s2_valid <= 1'b0;
        end
    end

    // gradient words
    always_comb begin
        if (r_s2_op.first) begin
            gx = SCALE_MARK;
            gy = SCALE_MARK;
            gz = SCALE_MARK;
        end else begin
            gx = r_s2_op.face_x ? ZERO_LEVEL : grad_word(t_p1, r_t_m1);
            gy = r_s2_op.face_y ? ZERO_LEVEL : grad_word(t_px, t_mx);
            gz = r_s2_op.face_z ? ZERO_LEVEL : grad_word(r_t_pp, t_mp);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s2_move) begin
            r_o_valid <= 1'b1;
        end else if (i_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_o_data <= {gz, gy, gx};
            r_o_last <= r_s2_op.last;
        end
    end

    assign o_tvalid = r_o_valid;
    assign o_tdata  = r_o_data;
    assign o_tlast  = r_o_last;

endmodule

/* hw/rtl/volume_gradient_central_difference_unit.sv */
// ============================================================================
// volume_gradient_central_difference_unit
// Central-difference gradient of an 8-bit volume streamed in raster order.
// ============================================================================
// Throughput: one item per cycle unless held off or stalled, set by the single
//   push per cycle into the window delay memories (two plane lines, two row lines).
// Path: the result of voxel p leaves once the item carrying voxel p + dim_x*dim_y
//   (or the matching drain) has passed the queue, window and output registers.
// Reset: control cleared, dimensions 256^3; input held off after reset and after
//   each register write while the geometry settles.
module volume_gradient_central_difference_unit import vgcd_pkg::*; #(
    parameter int MAX_DIM_X = VGCD_MAX_X,
    parameter int MAX_DIM_Y = VGCD_MAX_Y,
    parameter int MAX_DIM_Z = VGCD_MAX_Z
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [12:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] voxel
    input  logic        s_axis_tuser,   // [0] drain
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] grad_x, [31:16] grad_y, [47:32] grad_z
    output logic        m_axis_tlast    // last
);

    localparam int XW  = $clog2(MAX_DIM_X + 1);
    localparam int YW  = $clog2(MAX_DIM_Y + 1);
    localparam int ZW  = $clog2(MAX_DIM_Z + 1);
    localparam int XPW = $clog2(MAX_DIM_X);
    localparam int YPW = $clog2(MAX_DIM_Y);
    localparam int ZPW = $clog2(MAX_DIM_Z);
    localparam int PLW = $clog2(MAX_DIM_X * MAX_DIM_Y + 1);
    localparam int CW  =
        $clog2(longint'(MAX_DIM_X) * longint'(MAX_DIM_Y) * longint'(MAX_DIM_Z) + 1);

    logic [8:0]  r_cfg_x;
    logic [8:0]  r_cfg_y;
    logic [12:0] r_cfg_z;
    logic [2:0]  r_settle;
    logic        restart;

    logic [XW-1:0]  r_dx, n_dx;
    logic [YW-1:0]  r_dy, n_dy;
    logic [ZW-1:0]  r_dz, n_dz;
    logic [PLW-1:0] r_plane;
    logic [CW-1:0]  r_total;
    logic [CW-1:0]  r_total_m1;
    logic [XPW-1:0] r_dx_m1;
    logic [YPW-1:0] r_dy_m1;
    logic [ZPW-1:0] r_dz_m1;
    logic [XW-1:0]  r_line_len;
    logic [PLW-1:0] r_plane_len;

    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_op  f_op;
    t_op  q_op;

    // register writes
    assign restart = i_cfg_we && (i_cfg_addr == CFG_DIM_X || i_cfg_addr == CFG_DIM_Y
                                  || i_cfg_addr == CFG_DIM_Z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_x <= 9'd256;
            r_cfg_y <= 9'd256;
            r_cfg_z <= 13'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DIM_X: r_cfg_x <= i_cfg_data[8:0];
                CFG_DIM_Y: r_cfg_y <= i_cfg_data[8:0];
                CFG_DIM_Z: r_cfg_z <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // input held off while the geometry settles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_settle <= SETTLE_CYC;
        end else if (r_settle != '0) begin
            r_settle <= r_settle - 3'd1;
        end
    end

    // clamp to legal sizes
    always_comb begin
        if (r_cfg_x < 9'd3)                 n_dx = XW'(3);
        else if (32'(r_cfg_x) > MAX_DIM_X)  n_dx = XW'(MAX_DIM_X);
        else                                n_dx = XW'(r_cfg_x);
        if (r_cfg_y < 9'd3)                 n_dy = YW'(3);
        else if (32'(r_cfg_y) > MAX_DIM_Y)  n_dy = YW'(MAX_DIM_Y);
        else                                n_dy = YW'(r_cfg_y);
        if (r_cfg_z < 13'd3)                n_dz = ZW'(3);
        else if (32'(r_cfg_z) > MAX_DIM_Z)  n_dz = ZW'(MAX_DIM_Z);
        else                                n_dz = ZW'(r_cfg_z);
    end

    // derived geometry, one multiplier per stage
    always_ff @(posedge i_clk) begin
        r_dx        <= n_dx;
        r_dy        <= n_dy;
        r_dz        <= n_dz;
        r_dx_m1     <= XPW'(r_dx - XW'(1));
        r_dy_m1     <= YPW'(r_dy - YW'(1));
        r_dz_m1     <= ZPW'(r_dz - ZW'(1));
        r_line_len  <= r_dx - XW'(2);
        r_plane     <= PLW'(r_dx * r_dy);
        r_plane_len <= r_plane - PLW'(r_dx) - PLW'(1);
        r_total     <= CW'(r_plane * r_dz);
        r_total_m1  <= r_total - CW'(1);
    end

    vgcd_front #(
        .MAX_DIM_X(MAX_DIM_X), .MAX_DIM_Y(MAX_DIM_Y), .MAX_DIM_Z(MAX_DIM_Z)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (restart),
        .i_hold     (r_settle != '0),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_voxel    (s_axis_tdata),
        .i_drain    (s_axis_tuser),
        .i_dx_m1    (r_dx_m1),
        .i_dy_m1    (r_dy_m1),
        .i_dz_m1    (r_dz_m1),
        .i_plane    (r_plane),
        .i_total    (r_total),
        .i_total_m1 (r_total_m1),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_op       (f_op)
    );

    vgcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (f_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    vgcd_back #(
        .MAX_DIM_X(MAX_DIM_X), .MAX_DIM_Y(MAX_DIM_Y)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_op      (q_op),
        .o_q_pop     (q_pop),
        .i_line_len  (r_line_len),
        .i_plane_len (r_plane_len),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tlast     (m_axis_tlast)
    );

    // a register write keeps the next item out
    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        restart |=> !s_axis_tready)
        else $error("item accepted right after a register write");

    // the front never pushes into a full queue
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue overflow");

    // the back never pops an empty queue
    a_queue_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue underflow");

endmodule
